@@ sv/interleaved_frame_deframer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Interleaved frame deframer assertion macros
// Shorthands for clocked implications, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define INTERLEAVED_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define IFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ifd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the interleaved frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LEN_W      = 2 * BYTE_W;
   localparam int unsigned MASK_W     = 64;
   localparam int unsigned SPACE_W    = 17;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned KIND_W     = 2;

   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h24;  // '$'

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SPACE = 2'd1;

   localparam logic [MASK_W-1:0]  CHANNEL_MASK_RST = 64'd3;
   localparam logic [SPACE_W-1:0] BUFFER_SPACE_RST = 17'h1_0000;

   localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   typedef enum logic [5:0] {
      PH_MARKER   = 6'b000001,
      PH_CHANNEL  = 6'b000010,
      PH_LEN_HIGH = 6'b000100,
      PH_LEN_LOW  = 6'b001000,
      PH_PAYLOAD  = 6'b010000,
      PH_ERROR    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [MASK_W-1:0]  channel_mask;
      logic [SPACE_W-1:0] buffer_space;
   } csr_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] channel;
      logic              frame_last;
   } result_type;

endpackage

@@ sv/interleaved_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// interleaved_frame_deframer_top
// Byte-wise parser for '$' / channel / 16-bit length / payload framing.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one received byte per item (req_in_byte); rsp_
//   channel returns exactly one result item per byte: header consumed,
//   payload byte with channel and frame_last, or error. An item moves when
//   valid is high and stall is low.
//   Path: an accepted byte is held in the input register, then the state
//   machine step writes the result register, which drives rsp_valid.
//   Throughput: one item per cycle while rsp_stall is low.
//   The csr_ port writes channel_mask (index 0) and buffer_space (index 1);
//   write only while no item is in flight.
//   Reset: synchronous; phase returns to marker hunt, registers to defaults,
//   both pipeline stages empty. An error stays until reset.
//   Stall: a stalled result holds in the output register; the input register
//   keeps one more byte, and req_stall rises once both are occupied.
// ----------------------------------------------------------------------------
module interleaved_frame_deframer_top
   import ifd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [BYTE_W-1:0]    rsp_payload_byte,
   output logic [BYTE_W-1:0]    rsp_channel,
   output logic                 rsp_frame_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASK_W-1:0]    csr_wdata
);

   csr_type           csr;
   result_type        result;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   logic              out_adv;
   logic              fire;

   ifd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   ifd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .csr     (csr),
      .result  (result)
   );

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_channel      = out_ff.channel;
   assign rsp_frame_last   = out_ff.frame_last;

endmodule

@@ sv/ifd_csr.sv @@
// ----------------------------------------------------------------------------
// ifd_csr
// Configuration registers: accepted channel mask and free buffer space.
// ----------------------------------------------------------------------------
module ifd_csr
   import ifd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MASK_W-1:0]    csr_wdata,
   output csr_type              csr
);

   logic [MASK_W-1:0]  channel_mask_ff, channel_mask_in;
   logic [SPACE_W-1:0] buffer_space_ff, buffer_space_in;

   always_comb begin
      channel_mask_in = channel_mask_ff;
      buffer_space_in = buffer_space_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_MASK: channel_mask_in = csr_wdata;
            CSR_BUFFER_SPACE: buffer_space_in = csr_wdata[SPACE_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_mask_ff <= CHANNEL_MASK_RST;
         buffer_space_ff <= BUFFER_SPACE_RST;
      end else begin
         channel_mask_ff <= channel_mask_in;
         buffer_space_ff <= buffer_space_in;
      end
   end

   assign csr.channel_mask = channel_mask_ff;
   assign csr.buffer_space = buffer_space_ff;

endmodule

@@ sv/ifd_parse.sv @@
// ----------------------------------------------------------------------------
// ifd_parse
// Framing state machine: marker, channel, length, payload, sticky error.
// ----------------------------------------------------------------------------
module ifd_parse
   import ifd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [BYTE_W-1:0] in_byte,
   input  csr_type           csr,
   output result_type        result
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] frame_channel_ff, frame_channel_in;
   logic [BYTE_W-1:0] length_high_ff, length_high_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [LEN_W-1:0]  frame_len;
   logic              chan_ok;

   assign frame_len = {length_high_ff, in_byte};
   // ids 64 and up are never accepted
   assign chan_ok = (in_byte[BYTE_W-1:6] == '0) && csr.channel_mask[in_byte[5:0]];

   always_comb begin
      phase_in            = phase_ff;
      frame_channel_in    = frame_channel_ff;
      length_high_in      = length_high_ff;
      bytes_left_in       = bytes_left_ff;
      result.kind         = KIND_HEADER;
      result.payload_byte = '0;
      result.frame_last   = 1'b0;

      case (phase_ff)
         PH_MARKER: begin
            if (in_byte == MARKER_BYTE) begin
               frame_channel_in = '0;
               phase_in         = PH_CHANNEL;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_CHANNEL: begin
            frame_channel_in = in_byte;
            phase_in         = chan_ok ? PH_LEN_HIGH : PH_ERROR;
         end
         PH_LEN_HIGH: begin
            length_high_in = in_byte;
            phase_in       = PH_LEN_LOW;
         end
         PH_LEN_LOW: begin
            if ((frame_len == '0) || ({1'b0, frame_len} >= csr.buffer_space)) begin
               phase_in = PH_ERROR;
            end else begin
               bytes_left_in = frame_len;
               phase_in      = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = in_byte;
            if (bytes_left_ff[LEN_W-1:1] == '0) begin
               bytes_left_in     = '0;
               result.frame_last = 1'b1;
               phase_in          = PH_MARKER;
            end else begin
               bytes_left_in = bytes_left_ff - LEN_W'(1);
            end
         end
         default: phase_in = PH_ERROR;
      endcase

      if (phase_in == PH_ERROR) begin
         result.kind         = KIND_ERROR;
         result.payload_byte = '0;
         result.frame_last   = 1'b0;
      end
      result.channel = frame_channel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_MARKER;
         frame_channel_ff <= '0;
         length_high_ff   <= '0;
         bytes_left_ff    <= '0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         frame_channel_ff <= frame_channel_in;
         length_high_ff   <= length_high_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

endmodule

@@ sv/ifd_checker.sv @@
// ----------------------------------------------------------------------------
// ifd_checker
// Port-level checks on the result stream of the deframer.
// ----------------------------------------------------------------------------
`include "interleaved_frame_deframer_top_assert.svh"

module ifd_checker
   import ifd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [KIND_W-1:0] rsp_kind,
   input  logic [BYTE_W-1:0] rsp_payload_byte,
   input  logic              rsp_frame_last
);

   logic rsp_fire;
   logic seen_error_ff, seen_error_in;
   logic after_last_ff, after_last_in;
   logic plain_valid;
   logic data_clear;
   logic error_due;
   logic is_error;
   logic header_due;
   logic not_payload;

   assign rsp_fire = rsp_valid && !rsp_stall;

   // error seen on an accepted result; must persist
   assign seen_error_in = seen_error_ff || (rsp_fire && (rsp_kind == KIND_ERROR));
   // frame just closed; next result cannot be payload
   assign after_last_in = rsp_fire ? rsp_frame_last : after_last_ff;

   assign plain_valid = rsp_valid && (rsp_kind != KIND_PAYLOAD);
   assign data_clear  = (rsp_payload_byte == '0) && !rsp_frame_last;
   assign error_due   = rsp_valid && seen_error_ff;
   assign is_error    = (rsp_kind == KIND_ERROR);
   assign header_due  = rsp_valid && after_last_ff;
   assign not_payload = (rsp_kind != KIND_PAYLOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_error_ff <= 1'b0;
         after_last_ff <= 1'b0;
      end else begin
         seen_error_ff <= seen_error_in;
         after_last_ff <= after_last_in;
      end
   end

   `IFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   `IFD_ASSERT_NOW(a_non_payload_clean, plain_valid, data_clear, "non-payload carries data")

   `IFD_ASSERT_NOW(a_error_sticky, error_due, is_error, "left error state without reset")

   `IFD_ASSERT_NOW(a_marker_after_last, header_due, not_payload, "payload follows end of frame")

endmodule

bind interleaved_frame_deframer_top ifd_checker u_ifd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_last   (rsp_frame_last)
);

@@ dv/interleaved_frame_deframer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interleaved_frame_deframer_top_tb
// Streams '$'/channel/length/payload frames through the deframer under
// several mask and buffer space settings, with sender gaps, receiver stalls
// and one long receiver hold. A closing fault, picked at random, drives the
// parser into its sticky error. Every result item is checked against an
// in-bench parser model.
// ----------------------------------------------------------------------------
module interleaved_frame_deframer_top_tb;
   import ifd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [MASK_W-1:0] MASK_ALL = '1;

   typedef enum int {
      ERR_MARKER,
      ERR_CHANNEL_MASK,
      ERR_CHANNEL_RANGE,
      ERR_ZERO_LEN,
      ERR_TOO_LONG
   } fault_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic [BYTE_W-1:0]    rsp_channel;
   logic                 rsp_frame_last;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [MASK_W-1:0]    csr_wdata   = '0;

   // parser model: configuration and state
   logic [MASK_W-1:0]    accept_mask  = CHANNEL_MASK_RST;
   logic [SPACE_W-1:0]   rx_space     = BUFFER_SPACE_RST;
   phase_type            parse_phase  = PH_MARKER;
   logic [BYTE_W-1:0]    frame_chan   = '0;
   logic [BYTE_W-1:0]    len_msb      = '0;
   logic [LEN_W-1:0]     payload_left = '0;

   result_type parse_results_q[$];
   result_type want;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   fault_type   fault = ERR_MARKER;

   interleaved_frame_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_channel      (rsp_channel),
      .rsp_frame_last   (rsp_frame_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, parse_results_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold while hold_left runs down
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (parse_results_q.size() == 0) begin
            report_mismatch($sformatf("result item with nothing expected, kind %0d", rsp_kind));
         end else begin
            want = parse_results_q.pop_front();
            results_checked++;
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch($sformatf("payload_byte got %0h want %0h",
                                         rsp_payload_byte, want.payload_byte));
            if (rsp_channel !== want.channel)
               report_mismatch($sformatf("channel got %0d want %0d",
                                         rsp_channel, want.channel));
            if (rsp_frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last got %0b want %0b",
                                         rsp_frame_last, want.frame_last));
         end
      end
   end

   // one parser step: advances the model state, returns the result item
   function automatic result_type parse_byte(input logic [BYTE_W-1:0] b);
      result_type r;
      logic [LEN_W:0] frame_len;
      r.kind = KIND_HEADER;
      r.payload_byte = '0;
      r.frame_last = 1'b0;
      case (parse_phase)
         PH_MARKER: begin
            if (b == MARKER_BYTE) begin
               frame_chan = '0;
               parse_phase = PH_CHANNEL;
            end else begin
               parse_phase = PH_ERROR;
            end
         end
         PH_CHANNEL: begin
            frame_chan = b;
            parse_phase = (b < MASK_W && accept_mask[b[5:0]]) ? PH_LEN_HIGH : PH_ERROR;
         end
         PH_LEN_HIGH: begin
            len_msb = b;
            parse_phase = PH_LEN_LOW;
         end
         PH_LEN_LOW: begin
            frame_len = {1'b0, len_msb, b};
            if (frame_len == 0 || frame_len >= rx_space) begin
               parse_phase = PH_ERROR;
            end else begin
               payload_left = frame_len[LEN_W-1:0];
               parse_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            if (payload_left <= 1) begin
               payload_left = '0;
               r.frame_last = 1'b1;
               parse_phase = PH_MARKER;
            end else begin
               payload_left = payload_left - 1'b1;
            end
         end
         default: parse_phase = PH_ERROR;
      endcase
      if (parse_phase == PH_ERROR) begin
         r.kind = KIND_ERROR;
         r.payload_byte = '0;
         r.frame_last = 1'b0;
      end
      r.channel = frame_chan;
      return r;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_results_q.push_back(parse_byte(b));
      items_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (parse_results_q.size() != 0) @(posedge clock);
   endtask

   // writes both registers, then an unused index that must be ignored;
   // bits above the space field carry noise
   task automatic set_config(input logic [MASK_W-1:0] mask, input logic [SPACE_W-1:0] space);
      logic [MASK_W-1:0] noise;
      noise = {$urandom, $urandom};
      csr_we <= 1'b1;
      csr_index <= CSR_CHANNEL_MASK;
      csr_wdata <= mask;
      @(posedge clock);
      accept_mask = mask;
      csr_index <= CSR_BUFFER_SPACE;
      csr_wdata <= {noise[MASK_W-1:SPACE_W], space};
      @(posedge clock);
      rx_space = space;
      csr_index <= CSR_UNUSED;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] pick_channel();
      logic [BYTE_W-1:0] id;
      do id = BYTE_W'($urandom_range(MASK_W - 1)); while (!accept_mask[id[5:0]]);
      return id;
   endfunction

   task automatic send_frame(input logic [BYTE_W-1:0] chan, input logic [LEN_W-1:0] len);
      send_byte(MARKER_BYTE);
      send_byte(chan);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      // payload sometimes carries a marker byte, which must pass through
      repeat (len) send_byte(($urandom_range(9) == 0) ? MARKER_BYTE : BYTE_W'($urandom));
      frames_sent++;
   endtask

   task automatic random_frame();
      int unsigned longest;
      int unsigned len;
      longest = (rx_space > 17'h1_0000) ? 65535 : rx_space - 1;
      len = ($urandom_range(39) == 0) ? $urandom_range(256, 280) : $urandom_range(1, 16);
      if (len > longest) len = $urandom_range(1, longest);
      send_frame(pick_channel(), LEN_W'(len));
   endtask

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      send_frame(8'd0, 16'd1);   // reset mask, shortest frame
      send_byte(MARKER_BYTE);
      send_byte(8'd1);
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(8'hFF);
      send_byte(MARKER_BYTE);
      send_byte(8'h00);
      drain_pipeline();
      set_config(MASK_ALL, BUFFER_SPACE_RST);
      send_frame(8'd63, 16'd2);
      drain_pipeline();
      // length one below the space limit is still accepted
      set_config(64'd1 << 40, 17'd5);
      send_frame(8'd40, 16'd4);
   endtask

   task automatic test_traffic(input int unsigned idle, input int unsigned stall,
                               input logic [MASK_W-1:0] mask, input logic [SPACE_W-1:0] space,
                               input int unsigned n_items);
      int unsigned start;
      drain_pipeline();
      set_config(mask, space);
      idle_pct = idle;
      stall_pct = stall;
      start = items_sent;
      while (items_sent - start < n_items) random_frame();
   endtask

   task automatic test_backpressure();
      int unsigned start;
      drain_pipeline();
      idle_pct = 0;
      stall_pct = 0;
      hold_left = 300;
      start = items_sent;
      while (items_sent - start < 150) random_frame();
   endtask

   task automatic test_sticky_error();
      logic [MASK_W-1:0]  mask;
      logic [SPACE_W-1:0] space;
      logic [BYTE_W-1:0]  bad_id;
      logic [LEN_W-1:0]   len;
      fault = fault_type'($urandom_range(ERR_TOO_LONG));
      mask = {$urandom, $urandom} | 64'd1;
      space = SPACE_W'($urandom_range(2, 65536));
      bad_id = BYTE_W'($urandom_range(MASK_W - 1));
      case (fault)
         ERR_CHANNEL_MASK: mask = $urandom_range(1) ? '0 : mask & ~(64'd1 << bad_id);
         ERR_TOO_LONG:     space = $urandom_range(1) ? '0 : SPACE_W'($urandom_range(1, 65535));
         default: ;
      endcase
      drain_pipeline();
      set_config(mask, space);
      idle_pct = 27;
      stall_pct = 27;
      if (accept_mask != 0 && rx_space > 1) random_frame();
      case (fault)
         ERR_MARKER: send_byte(MARKER_BYTE ^ BYTE_W'($urandom_range(1, 255)));
         ERR_CHANNEL_MASK: begin
            send_byte(MARKER_BYTE);
            send_byte(bad_id);
         end
         ERR_CHANNEL_RANGE: begin
            send_byte(MARKER_BYTE);
            send_byte(BYTE_W'($urandom_range(MASK_W, 255)));
         end
         ERR_ZERO_LEN: send_frame(pick_channel(), '0);
         ERR_TOO_LONG: begin
            len = LEN_W'($urandom_range(space, 65535));
            send_byte(MARKER_BYTE);
            send_byte(pick_channel());
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: ;
      endcase
      // error must hold no matter what follows, well-formed frames included
      repeat (24) send_byte(($urandom_range(3) == 0) ? MARKER_BYTE : BYTE_W'($urandom));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_traffic(0, 0, MASK_ALL, BUFFER_SPACE_RST, 330);
      test_traffic(67, 0, {$urandom, $urandom} | (64'd1 << 63), 17'd2, 330);
      test_traffic(0, 67, {$urandom, $urandom} | 64'd1, SPACE_W'($urandom_range(20, 600)), 330);
      test_traffic(27, 27, 64'd1 << $urandom_range(63), BUFFER_SPACE_RST, 330);
      test_backpressure();
      test_sticky_error();
      stall_pct = 0;
      drain_pipeline();
      repeat (8) @(posedge clock);
      $display("Ran %0d bytes in %0d frames across idle, stall and hold phases",
               items_sent, frames_sent);
      $display("Closing fault %s; %0d result items checked, %0d mismatches",
               fault.name(), results_checked, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
